// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define RSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsi assertion failed");

// Next-cycle implication, masked during reset.
`define RSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsi assertion failed");

// Next-cycle implication that also holds across reset.
`define RSI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rsi assertion failed");

`endif

// ===== design/rsi_pkg.sv =====
// Package: widths and payload types of the ray against sphere test.
package rsi_pkg;

   // Fixed point position of all coordinates, radius and limits
   localparam int FRAC_BITS = 16;

   localparam int CRD_W   = 32;           // coordinate and limit width
   localparam int RAD_W   = 31;           // radius width
   localparam int O_W     = CRD_W + 1;    // origin minus centre
   localparam int DD_W    = 2 * CRD_W;    // d*d
   localparam int OD_W    = O_W + CRD_W;  // o*d
   localparam int OO_W    = 2 * O_W;      // o*o
   localparam int RR_W    = 2 * RAD_W;    // r*r
   localparam int A_W     = 64;           // |d|^2
   localparam int H_W     = 66;           // o.d, signed
   localparam int C_W     = 67;           // |o|^2 - r^2, signed
   localparam int HM_W    = H_W - 1;      // magnitude of h
   localparam int CM_W    = C_W - 1;      // magnitude of c
   localparam int PROD_W  = 130;          // h*h and a*|c|
   localparam int D_W     = 132;          // discriminant, signed, even width
   localparam int ROOT_W  = D_W / 2;      // square root bits
   localparam int SQR_W   = ROOT_W + 2;   // square root remainder
   localparam int NS_W    = 68;           // -h -/+ root, signed
   localparam int QUO_W   = NS_W - 1 + FRAC_BITS; // dividend and quotient bits
   localparam int T_W     = QUO_W + 1;    // signed root in Q.FRAC_BITS

   typedef struct packed {
      logic signed [CRD_W-1:0] origin_x;
      logic signed [CRD_W-1:0] origin_y;
      logic signed [CRD_W-1:0] origin_z;
      logic signed [CRD_W-1:0] dir_x;
      logic signed [CRD_W-1:0] dir_y;
      logic signed [CRD_W-1:0] dir_z;
      logic signed [CRD_W-1:0] center_x;
      logic signed [CRD_W-1:0] center_y;
      logic signed [CRD_W-1:0] center_z;
      logic        [RAD_W-1:0] sphere_radius;
      logic signed [CRD_W-1:0] t_near;
      logic signed [CRD_W-1:0] t_far;
   } rsi_req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [CRD_W-1:0] hit_distance;
   } rsi_rsp_type;

endpackage

// ===== design/rsi_if.sv =====
// Interfaces: request and response channels of the ray against sphere test.
interface rsi_req_if;
   logic                 valid;
   logic                 ready;
   rsi_pkg::rsi_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rsi_rsp_if;
   logic                 valid;
   logic                 ready;
   rsi_pkg::rsi_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ray_sphere_intersect_top.sv =====
// Top level: fully pipelined ray against sphere intersection test.
//
// Usage
//   req carries one ray (origin, direction, near and far limits) and one
//   sphere (centre, radius), Q16.16 (radius Q15.16). rsp returns hit and the
//   hit distance (near root, or far root if the near root is negative),
//   saturated to 32 bits and zero on a miss. Both are valid/ready channels.
// Throughput
//   One transaction per cycle unless rsp stalls. Every stage is a register
//   slice: the vector products, the wide h*h and a*c products from partials
//   split at bit 33 (a at bit 32), a square root resolving one root bit per
//   stage (66 stages) and two restoring dividers, one quotient bit per stage.
// Stages
//   From req acceptance to rsp valid: 7 front stages, 66 root stages,
//   2 numerator stages, 83 divide stages, fix-up and output.
// Stall
//   When rsp holds a result and rsp.ready is low the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated.
// Reset
//   Synchronous reset clears the valid bits only and holds req.ready low;
//   the pipeline comes out of reset empty and accepts once reset is low.
module ray_sphere_intersect_top (
   input  logic   clock,
   input  logic   reset,
   rsi_req_if.sink   req,
   rsi_rsp_if.source rsp
);

   localparam int CRD_W  = rsi_pkg::CRD_W;
   localparam int RAD_W  = rsi_pkg::RAD_W;
   localparam int O_W    = rsi_pkg::O_W;
   localparam int DD_W   = rsi_pkg::DD_W;
   localparam int OD_W   = rsi_pkg::OD_W;
   localparam int OO_W   = rsi_pkg::OO_W;
   localparam int RR_W   = rsi_pkg::RR_W;
   localparam int A_W    = rsi_pkg::A_W;
   localparam int H_W    = rsi_pkg::H_W;
   localparam int C_W    = rsi_pkg::C_W;
   localparam int HM_W   = rsi_pkg::HM_W;
   localparam int CM_W   = rsi_pkg::CM_W;
   localparam int PROD_W = rsi_pkg::PROD_W;
   localparam int D_W    = rsi_pkg::D_W;
   localparam int ROOT_W = rsi_pkg::ROOT_W;
   localparam int SQR_W  = rsi_pkg::SQR_W;
   localparam int NS_W   = rsi_pkg::NS_W;
   localparam int QW     = rsi_pkg::QUO_W;
   localparam int TW     = rsi_pkg::T_W;
   localparam int FRAC   = rsi_pkg::FRAC_BITS;
   localparam int HL_W   = 33;            // low split of h and c magnitudes
   localparam int AL_W   = A_W / 2;       // split of a
   localparam int NSTG   = 7 + ROOT_W + 2 + QW + 2;

   // Side data travelling with each transaction
   typedef struct packed {
      logic signed [H_W-1:0]   h;
      logic        [A_W-1:0]   a;
      logic                    miss;
      logic signed [CRD_W-1:0] tn;
      logic signed [CRD_W-1:0] tf;
   } side_type;

   typedef struct packed {
      logic [SQR_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [D_W-1:0]    dv;
      side_type          side;
   } sq_type;

   typedef struct packed {
      logic [QW-1:0]  n0;
      logic [QW-1:0]  n1;
      logic [A_W-1:0] r0;
      logic [A_W-1:0] r1;
      logic           neg0;
      logic           neg1;
      side_type       side;
   } dv_type;

   typedef struct packed {
      logic signed [TW-1:0] t0;
      logic signed [TW-1:0] t1;
      side_type             side;
   } fx_type;

   // Pipeline control
   logic            en;
   logic [NSTG-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[NSTG-1] || rsp.ready;
   assign req.ready = en && !reset;
   assign rsp.valid = vld_ff[NSTG-1];
   assign vld_in    = {vld_ff[NSTG-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: origin relative to the centre
   logic signed [O_W-1:0]   s1_o_ff [3], s1_o_in [3];
   logic signed [CRD_W-1:0] s1_d_ff [3], s1_d_in [3];
   logic        [RAD_W-1:0] s1_r_ff, s1_r_in;
   logic signed [CRD_W-1:0] s1_tn_ff, s1_tn_in, s1_tf_ff, s1_tf_in;

   always_comb begin
      s1_o_in[0] = O_W'(req.payload.origin_x) - O_W'(req.payload.center_x);
      s1_o_in[1] = O_W'(req.payload.origin_y) - O_W'(req.payload.center_y);
      s1_o_in[2] = O_W'(req.payload.origin_z) - O_W'(req.payload.center_z);
      s1_d_in[0] = req.payload.dir_x;
      s1_d_in[1] = req.payload.dir_y;
      s1_d_in[2] = req.payload.dir_z;
      s1_r_in    = req.payload.sphere_radius;
      s1_tn_in   = req.payload.t_near;
      s1_tf_in   = req.payload.t_far;
   end

   // Stage 2: component products
   logic signed [DD_W-1:0]  s2_dd_ff [3], s2_dd_in [3];
   logic signed [OD_W-1:0]  s2_od_ff [3], s2_od_in [3];
   logic signed [OO_W-1:0]  s2_oo_ff [3], s2_oo_in [3];
   logic        [RR_W-1:0]  s2_rr_ff, s2_rr_in;
   logic signed [CRD_W-1:0] s2_tn_ff, s2_tf_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_dd_in[i] = s1_d_ff[i] * s1_d_ff[i];
         s2_od_in[i] = s1_o_ff[i] * s1_d_ff[i];
         s2_oo_in[i] = s1_o_ff[i] * s1_o_ff[i];
      end
      s2_rr_in = s1_r_ff * s1_r_ff;
   end

   // Stage 3: a, h and c
   logic signed [C_W-1:0] s3_c_ff, s3_c_in;
   side_type              s3_sd_ff, s3_sd_in;

   always_comb begin
      s3_sd_in.a    = A_W'($unsigned(s2_dd_ff[0])) + A_W'($unsigned(s2_dd_ff[1]))
                    + A_W'($unsigned(s2_dd_ff[2]));
      s3_sd_in.h    = H_W'(s2_od_ff[0]) + H_W'(s2_od_ff[1]) + H_W'(s2_od_ff[2]);
      s3_c_in       = C_W'(s2_oo_ff[0]) + C_W'(s2_oo_ff[1]) + C_W'(s2_oo_ff[2])
                    - C_W'(s2_rr_ff);
      s3_sd_in.miss = 1'b0;
      s3_sd_in.tn   = s2_tn_ff;
      s3_sd_in.tf   = s2_tf_ff;
   end

   // Stage 4: magnitudes of h and c, zero direction check
   logic [HM_W-1:0] s4_hm_ff, s4_hm_in;
   logic [CM_W-1:0] s4_cm_ff, s4_cm_in;
   logic            s4_cn_ff, s4_cn_in;
   side_type        s4_sd_ff, s4_sd_in;

   always_comb begin
      s4_hm_in      = s3_sd_ff.h[H_W-1] ? HM_W'(-s3_sd_ff.h) : HM_W'(s3_sd_ff.h);
      s4_cn_in      = s3_c_ff[C_W-1];
      s4_cm_in      = s3_c_ff[C_W-1] ? CM_W'(-s3_c_ff) : CM_W'(s3_c_ff);
      s4_sd_in      = s3_sd_ff;
      s4_sd_in.miss = (s3_sd_ff.a == '0);
   end

   // Stage 5: partial products of h*h and a*|c|
   logic [2*HL_W-1:0]         s5_hll_ff, s5_hll_in;
   logic [HL_W+HM_W-HL_W-1:0] s5_hlh_ff, s5_hlh_in;
   logic [2*(HM_W-HL_W)-1:0]  s5_hhh_ff, s5_hhh_in;
   logic [AL_W+HL_W-1:0]      s5_ac_ff [4], s5_ac_in [4];
   logic                      s5_cn_ff;
   side_type                  s5_sd_ff;

   always_comb begin
      s5_hll_in   = s4_hm_ff[HL_W-1:0] * s4_hm_ff[HL_W-1:0];
      s5_hlh_in   = s4_hm_ff[HL_W-1:0] * s4_hm_ff[HM_W-1:HL_W];
      s5_hhh_in   = s4_hm_ff[HM_W-1:HL_W] * s4_hm_ff[HM_W-1:HL_W];
      s5_ac_in[0] = s4_sd_ff.a[AL_W-1:0]   * s4_cm_ff[HL_W-1:0];
      s5_ac_in[1] = s4_sd_ff.a[AL_W-1:0]   * s4_cm_ff[CM_W-1:HL_W];
      s5_ac_in[2] = s4_sd_ff.a[A_W-1:AL_W] * s4_cm_ff[HL_W-1:0];
      s5_ac_in[3] = s4_sd_ff.a[A_W-1:AL_W] * s4_cm_ff[CM_W-1:HL_W];
   end

   // Stage 6: recombine the partials
   logic [PROD_W-1:0] s6_hh_ff, s6_hh_in, s6_ac_ff, s6_ac_in;
   logic              s6_cn_ff;
   side_type          s6_sd_ff;

   always_comb begin
      s6_hh_in = PROD_W'(s5_hll_ff) + (PROD_W'(s5_hlh_ff) << (HL_W + 1))
               + (PROD_W'(s5_hhh_ff) << (2 * HL_W));
      s6_ac_in = PROD_W'(s5_ac_ff[0]) + (PROD_W'(s5_ac_ff[1]) << HL_W)
               + (PROD_W'(s5_ac_ff[2]) << AL_W) + (PROD_W'(s5_ac_ff[3]) << (AL_W + HL_W));
   end

   // Stage 7 and square root stages: one root bit per stage
   sq_type sq_ff [ROOT_W+1];
   sq_type sq_in [ROOT_W+1];

   always_comb begin
      logic [D_W-1:0] disc;
      disc = s6_cn_ff ? D_W'(s6_hh_ff) + D_W'(s6_ac_ff) : D_W'(s6_hh_ff) - D_W'(s6_ac_ff);
      sq_in[0].rem       = '0;
      sq_in[0].root      = '0;
      sq_in[0].dv        = disc;
      sq_in[0].side      = s6_sd_ff;
      sq_in[0].side.miss = s6_sd_ff.miss || disc[D_W-1];
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      logic [SQR_W+1:0] r2, trial;
      logic             ge;
      always_comb begin
         r2    = {sq_ff[k-1].rem, sq_ff[k-1].dv[D_W-1 -: 2]};
         trial = {2'b00, sq_ff[k-1].root, 2'b01};
         ge    = (r2 >= trial);
         sq_in[k].rem  = ge ? SQR_W'(r2 - trial) : SQR_W'(r2);
         sq_in[k].root = {sq_ff[k-1].root[ROOT_W-2:0], ge};
         sq_in[k].dv   = {sq_ff[k-1].dv[D_W-3:0], 2'b00};
         sq_in[k].side = sq_ff[k-1].side;
      end
   end

   // Numerators -h - s and -h + s
   logic [NS_W-1:0] nm_n0_ff, nm_n0_in, nm_n1_ff, nm_n1_in;
   side_type        nm_sd_ff;

   always_comb begin
      nm_n0_in = NS_W'(0) - NS_W'(sq_ff[ROOT_W].side.h) - NS_W'(sq_ff[ROOT_W].root);
      nm_n1_in = NS_W'(0) - NS_W'(sq_ff[ROOT_W].side.h) + NS_W'(sq_ff[ROOT_W].root);
   end

   // Magnitudes, scaled to Q.FRAC, then restoring divide stages
   dv_type dv_ff [QW+1];
   dv_type dv_in [QW+1];

   always_comb begin
      logic [NS_W-1:0] m0, m1;
      m0 = nm_n0_ff[NS_W-1] ? -nm_n0_ff : nm_n0_ff;
      m1 = nm_n1_ff[NS_W-1] ? -nm_n1_ff : nm_n1_ff;
      dv_in[0].n0   = {m0[NS_W-2:0], FRAC'(0)};
      dv_in[0].n1   = {m1[NS_W-2:0], FRAC'(0)};
      dv_in[0].r0   = '0;
      dv_in[0].r1   = '0;
      dv_in[0].neg0 = nm_n0_ff[NS_W-1];
      dv_in[0].neg1 = nm_n1_ff[NS_W-1];
      dv_in[0].side = nm_sd_ff;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [A_W:0] p0, p1, dsr;
      logic         ge0, ge1;
      always_comb begin
         dsr = {1'b0, dv_ff[k-1].side.a};
         p0  = {dv_ff[k-1].r0, dv_ff[k-1].n0[QW-1]};
         p1  = {dv_ff[k-1].r1, dv_ff[k-1].n1[QW-1]};
         ge0 = (p0 >= dsr);
         ge1 = (p1 >= dsr);
         dv_in[k]    = dv_ff[k-1];
         dv_in[k].r0 = ge0 ? A_W'(p0 - dsr) : A_W'(p0);
         dv_in[k].r1 = ge1 ? A_W'(p1 - dsr) : A_W'(p1);
         dv_in[k].n0 = {dv_ff[k-1].n0[QW-2:0], ge0};
         dv_in[k].n1 = {dv_ff[k-1].n1[QW-2:0], ge1};
      end
   end

   // Floor correction and sign of the roots
   fx_type fx_ff, fx_in;

   always_comb begin
      logic [TW-1:0] q0, q1;
      q0 = TW'(dv_ff[QW].n0) + TW'(dv_ff[QW].neg0 && (dv_ff[QW].r0 != '0));
      q1 = TW'(dv_ff[QW].n1) + TW'(dv_ff[QW].neg1 && (dv_ff[QW].r1 != '0));
      fx_in.t0   = dv_ff[QW].neg0 ? -$signed(q0) : $signed(q0);
      fx_in.t1   = dv_ff[QW].neg1 ? -$signed(q1) : $signed(q1);
      fx_in.side = dv_ff[QW].side;
   end

   // Limit tests and saturation into the output register
   rsi_pkg::rsi_rsp_type out_ff, out_in;

   always_comb begin
      logic signed [TW-1:0] ln, lf, sel;
      logic                 out_b, in_b, fits;
      ln    = TW'(fx_ff.side.tn);
      lf    = TW'(fx_ff.side.tf);
      out_b = !((fx_ff.t0 <= lf) && (fx_ff.t1 >= ln));
      in_b  = (fx_ff.t0 < ln) && (fx_ff.t1 > lf);
      sel   = fx_ff.t0[TW-1] ? fx_ff.t1 : fx_ff.t0;
      fits  = (sel[TW-1:CRD_W-1] == '0) || (sel[TW-1:CRD_W-1] == '1);
      out_in.hit = !fx_ff.side.miss && !out_b && !in_b;
      if (!out_in.hit) begin
         out_in.hit_distance = '0;
      end else if (fits) begin
         out_in.hit_distance = sel[CRD_W-1:0];
      end else if (sel[TW-1]) begin
         out_in.hit_distance = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
         out_in.hit_distance = {1'b0, {(CRD_W-1){1'b1}}};
      end
   end

   assign rsp.payload = out_ff;

   // Payload registers, all advancing together
   always_ff @(posedge clock) begin
      if (en) begin
         s1_o_ff  <= s1_o_in;
         s1_d_ff  <= s1_d_in;
         s1_r_ff  <= s1_r_in;
         s1_tn_ff <= s1_tn_in;
         s1_tf_ff <= s1_tf_in;
         s2_dd_ff <= s2_dd_in;
         s2_od_ff <= s2_od_in;
         s2_oo_ff <= s2_oo_in;
         s2_rr_ff <= s2_rr_in;
         s2_tn_ff <= s1_tn_ff;
         s2_tf_ff <= s1_tf_ff;
         s3_c_ff  <= s3_c_in;
         s3_sd_ff <= s3_sd_in;
         s4_hm_ff <= s4_hm_in;
         s4_cm_ff <= s4_cm_in;
         s4_cn_ff <= s4_cn_in;
         s4_sd_ff <= s4_sd_in;
         s5_hll_ff <= s5_hll_in;
         s5_hlh_ff <= s5_hlh_in;
         s5_hhh_ff <= s5_hhh_in;
         s5_ac_ff <= s5_ac_in;
         s5_cn_ff <= s4_cn_ff;
         s5_sd_ff <= s4_sd_ff;
         s6_hh_ff <= s6_hh_in;
         s6_ac_ff <= s6_ac_in;
         s6_cn_ff <= s5_cn_ff;
         s6_sd_ff <= s5_sd_ff;
         sq_ff    <= sq_in;
         nm_n0_ff <= nm_n0_in;
         nm_n1_ff <= nm_n1_in;
         nm_sd_ff <= sq_ff[ROOT_W].side;
         dv_ff    <= dv_in;
         fx_ff    <= fx_in;
         out_ff   <= out_in;
      end
   end

endmodule

// ===== design/rsi_checker.sv =====
// Checker: port level assertions of the ray against sphere test, bound to the top.
`include "assert_macros.svh"

module rsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_hit_distance
);

   // A waiting result stays offered
   `RSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A miss always reports distance zero
   `RSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_hit_distance == '0)

   // A stalled result backs up the whole pipeline
   `RSI_ASSERT_IMP(a_stall_back, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // Reset empties the pipeline
   `RSI_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_hit          (rsp.payload.hit),
   .rsp_hit_distance (rsp.payload.hit_distance)
);

// ===== tb/sv/tb_ray_sphere_intersect_top.sv =====
// Testbench: ray against sphere test, table walk then random rays, checked against a wide predictor.
module tb_ray_sphere_intersect_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM   = 1800;
   localparam int QUIET_TAIL = 150;
   localparam int HOLD_AT    = 600;
   localparam int HOLD_LEN   = 500;
   localparam int DRAIN_WAIT = 200;
   localparam int STALL_MAX  = 3000;
   localparam int MAX_SHOWN  = 10;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   typedef logic signed [191:0] wide_type;

   typedef struct {
      rsi_pkg::rsi_req_type ray;
      bit                   typed;
      rsi_pkg::rsi_rsp_type want;
   } row_type;

   logic clock;
   logic reset;
   rsi_req_if req_ch ();
   rsi_rsp_if rsp_ch ();

   ray_sphere_intersect_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   rsi_pkg::rsi_rsp_type pending_hits[$];
   int  n_accepted = 0;
   int  n_total    = 0;
   int  n_errors   = 0;
   int  stall_cnt  = 0;
   bit  quiet      = 0;
   bit  held       = 0;
   row_type rows[$];

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor division of a signed value by a positive one
   function automatic wide_type floor_div(input wide_type num, input wide_type den);
      wide_type q;
      q = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      return q;
   endfunction

   // expected outcome of one ray against one sphere, exact wide arithmetic
   function automatic rsi_pkg::rsi_rsp_type intersect_ray(input rsi_pkg::rsi_req_type r);
      wide_type ox, oy, oz, dx, dy, dz, rad;
      wide_type a, h, c, disc, root, cand, t0, t1, tn, tf, t_hit;
      rsi_pkg::rsi_rsp_type res;
      res = '0;
      ox = wide_type'(r.origin_x) - wide_type'(r.center_x);
      oy = wide_type'(r.origin_y) - wide_type'(r.center_y);
      oz = wide_type'(r.origin_z) - wide_type'(r.center_z);
      dx = wide_type'(r.dir_x);
      dy = wide_type'(r.dir_y);
      dz = wide_type'(r.dir_z);
      rad = $signed({161'b0, r.sphere_radius});
      a = dx * dx + dy * dy + dz * dz;
      h = ox * dx + oy * dy + oz * dz;
      c = ox * ox + oy * oy + oz * oz - rad * rad;
      if (a == 0) return res;
      disc = h * h - a * c;
      if (disc < 0) return res;
      // floor square root, one bit at a time
      root = 0;
      for (int b = 70; b >= 0; b--) begin
         cand = root | (wide_type'(1) <<< b);
         if (cand * cand <= disc) root = cand;
      end
      t0 = floor_div((-h - root) <<< rsi_pkg::FRAC_BITS, a);
      t1 = floor_div((-h + root) <<< rsi_pkg::FRAC_BITS, a);
      tn = wide_type'(r.t_near);
      tf = wide_type'(r.t_far);
      if (!(t0 <= tf && t1 >= tn)) return res;
      if (t0 < tn && t1 > tf) return res;
      t_hit = (t0 < 0) ? t1 : t0;
      res.hit = 1'b1;
      if (t_hit > wide_type'(32'sh7fff_ffff)) res.hit_distance = 32'sh7fff_ffff;
      else if (t_hit < -wide_type'(33'sh0_8000_0000)) res.hit_distance = 32'sh8000_0000;
      else res.hit_distance = t_hit[31:0];
      return res;
   endfunction

   function automatic rsi_pkg::rsi_req_type make_ray(
      input logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz, rad, tn, tf);
      rsi_pkg::rsi_req_type r;
      r = '{ox, oy, oz, dx, dy, dz, cx, cy, cz, rad[30:0], tn, tf};
      return r;
   endfunction

   function automatic logic signed [31:0] rnd_span(input int unsigned bits);
      return $signed($urandom_range(0, (1 << bits) - 1)) - $signed(1 << (bits - 1));
   endfunction

   // mostly rays aimed near a sphere, rest full-range noise or small-range rays
   function automatic rsi_pkg::rsi_req_type random_ray();
      rsi_pkg::rsi_req_type r;
      int unsigned pick;
      logic signed [31:0] cx, cy, cz;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 40) begin
         r = make_ray(rnd_span(20), rnd_span(20), rnd_span(20),
                      rnd_span(18), rnd_span(18), rnd_span(18),
                      rnd_span(20), rnd_span(20), rnd_span(20),
                      $urandom_range(0, 1 << 20), rnd_span(22), rnd_span(24));
      end else begin
         cx = $signed($urandom);
         cy = $signed($urandom);
         cz = $signed($urandom);
         r = make_ray(cx + rnd_span(21), cy + rnd_span(21), cz + rnd_span(21),
                      rnd_span(18), rnd_span(18), rnd_span(18), cx, cy, cz,
                      $urandom_range(0, 1 << 21), rnd_span(20),
                      $signed($urandom_range(0, 1 << 26)));
         if ($urandom_range(0, 9) == 0) begin
            r.t_near = r.t_far;
            r.t_far  = rnd_span(20);
         end
      end
      return r;
   endfunction

   // directed table, expectation typed where it is obvious
   initial begin
      // plain hit at 4.0
      rows.push_back('{make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 0, 100 * ONE),
                       1, '{1'b1, 32'sh0004_0000}});
      // zero direction
      rows.push_back('{make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 100 * ONE),
                       1, '{1'b0, 32'sh0}});
      // ray passes beside the sphere
      rows.push_back('{make_ray(0, 0, 0, ONE, 0, 0, 0, 10 * ONE, 0, ONE, 0, 100 * ONE),
                       1, '{1'b0, 32'sh0}});
      // origin inside the sphere: far root reported
      rows.push_back('{make_ray(0, 0, 0, 0, ONE, 0, 0, 0, 0, 3 * ONE, -50 * ONE, 50 * ONE),
                       0, '0});
      // limits enclosed by the root span
      rows.push_back('{make_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 9 * ONE, ONE, 2 * ONE),
                       1, '{1'b0, 32'sh0}});
      // sphere wholly behind the ray
      rows.push_back('{make_ray(0, 0, 0, 0, 0, ONE, 0, 0, -9 * ONE, ONE, 0, 100 * ONE),
                       1, '{1'b0, 32'sh0}});
      // origin just inside, tiny direction: far root clamps high
      rows.push_back('{make_ray(-ONE + 16, 0, 0, 1, 0, 0, 0, 0, 0, ONE,
                                32'sh8000_0000, 32'sh7fff_ffff), 1, '{1'b1, 32'sh7fff_ffff}});
      // tiny direction, sphere behind
      rows.push_back('{make_ray(0, 0, 0, 1, 0, 0, -9000 * ONE, 0, 0, ONE,
                                32'sh8000_0000, 0), 0, '0});
      // inverted limits
      rows.push_back('{make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 100 * ONE, 0),
                       0, '0});
      // tangent ray
      rows.push_back('{make_ray(0, ONE, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 0, 100 * ONE),
                       0, '0});
      // extremes of every field
      rows.push_back('{make_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff), 0, '0});
      rows.push_back('{make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff), 0, '0});
      rows.push_back('{make_ray(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0,
                                32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff),
                       0, '0});
      rows.push_back('{make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, 32'sh7fff_ffff, 0, 0),
                       0, '0});
      rows.push_back('{make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b0, 32'sh0}});
   end

   // acceptance monitor and checker
   always @(posedge clock) begin
      rsi_pkg::rsi_rsp_type got, want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (n_accepted < rows.size() && rows[n_accepted].typed)
               pending_hits.push_back(rows[n_accepted].want);
            else
               pending_hits.push_back(intersect_ray(req_ch.payload));
            n_accepted++;
            if (n_total > 0 && n_accepted > n_total - QUIET_TAIL) quiet = 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (pending_hits.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_SHOWN) $display("unexpected transaction: %p", got);
            end else begin
               want = pending_hits.pop_front();
               if (got.hit !== want.hit || got.hit_distance !== want.hit_distance) begin
                  n_errors++;
                  if (n_errors <= MAX_SHOWN)
                     $display("mismatch: exp hit=%0b dist=%h got hit=%0b dist=%h",
                              want.hit, want.hit_distance, got.hit, got.hit_distance);
               end
            end
         end
         // watchdog
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cnt = 0;
         else
            stall_cnt++;
         if (stall_cnt >= STALL_MAX) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // response side: random back-pressure plus one long hold
   initial begin
      int unsigned k;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && n_accepted >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            held = 1;
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, 8);
            rsp_ch.ready <= 1'b0;
            repeat (k - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_ray(input rsi_pkg::rsi_req_type r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // request side and end of run
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      #0;
      n_total = rows.size() + N_RANDOM;
      foreach (rows[i]) send_ray(rows[i].ray);
      for (int i = 0; i < N_RANDOM; i++) send_ray(random_ray());
      req_ch.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== ray_sphere_intersect_top.f =====
+incdir+design
design/rsi_pkg.sv
design/rsi_if.sv
design/ray_sphere_intersect_top.sv
design/rsi_checker.sv
tb/sv/tb_ray_sphere_intersect_top.sv
